@@ rtl/core/key_debounce_long_press_detector_assert.svh @@
// Assertion macros shared by the key debounce and press detector RTL.
// Each macro expands to one labeled concurrent assertion with an asynchronous reset guard.
`ifndef KEY_DEBOUNCE_LONG_PRESS_DETECTOR_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KDLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kdlp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kdlp assertion failed");

`endif

@@ rtl/core/kdlp_pkg.sv @@
// Shared widths, codes, reset values and types for the key debounce and press detector.
// No dependencies; every other file of the block but the assertion macro header refers to it by scoped names.
`default_nettype none

package kdlp_pkg;

	localparam int KEY_COUNT_DEF = 4;

	localparam int KEYS_W   = 4;
	localparam int ACTION_W = 4;
	localparam int DEB_W    = 8;
	localparam int LONG_W   = 16;
	localparam int HOLD_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [DEB_W-1:0]  DEB_RST  = DEB_W'(1);
	localparam logic [LONG_W-1:0] LONG_RST = LONG_W'(100);

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LONG     = CFG_IDX_W'(1);

	localparam logic [ACTION_W-1:0] ACT_NONE = ACTION_W'(0);

	typedef struct packed {
		logic [DEB_W-1:0]  debounce_ticks;
		logic [LONG_W-1:0] long_ticks;
	} kdlp_thr_t;

	typedef struct packed {
		logic short_pend;
		logic long_pend;
	} kdlp_pend_t;

	typedef struct packed {
		logic clr_short;
		logic clr_long;
	} kdlp_clr_t;

endpackage

`default_nettype wire

@@ rtl/core/kdlp_if.sv @@
// Valid/ready channel interfaces of the key detector: input items, results and register writes.
// Depends on kdlp_pkg for the payload widths.
`default_nettype none

interface kdlp_item_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [kdlp_pkg::KEYS_W-1:0] keys_pressed;

	modport source(output valid, operation, keys_pressed, input ready);
	modport sink(input valid, operation, keys_pressed, output ready);
endinterface

interface kdlp_result_if;
	logic                          valid;
	logic                          ready;
	logic [kdlp_pkg::ACTION_W-1:0] action_code;

	modport source(output valid, action_code, input ready);
	modport sink(input valid, action_code, output ready);
endinterface

interface kdlp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [kdlp_pkg::CFG_IDX_W-1:0]  index;
	logic [kdlp_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/kdlp_key_fsm.sv @@
// One key lane: released/debounce/pressed/long-held machine, hold counter and sticky event flags.
// Depends on kdlp_pkg for thresholds and the flag structs.
`default_nettype none

module kdlp_key_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic                 down,
	input  kdlp_pkg::kdlp_thr_t  thr,
	input  kdlp_pkg::kdlp_clr_t  clr,
	output kdlp_pkg::kdlp_pend_t pend
);

	localparam logic [1:0] PH_RELEASED = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE = 2'd1;
	localparam logic [1:0] PH_PRESSED  = 2'd2;
	localparam logic [1:0] PH_LONG     = 2'd3;

	logic [1:0]                  phase_q;
	logic [1:0]                  phase_d;
	logic [kdlp_pkg::HOLD_W-1:0] hold_q;
	logic [kdlp_pkg::HOLD_W-1:0] hold_d;
	logic [kdlp_pkg::HOLD_W-1:0] hold_inc;
	logic                        short_q;
	logic                        long_q;
	logic                        set_short;
	logic                        set_long;

	assign hold_inc = hold_q + kdlp_pkg::HOLD_W'(1);

	always_comb begin
		phase_d   = phase_q;
		hold_d    = hold_q;
		set_short = 1'b0;
		set_long  = 1'b0;
		if (tick) begin
			unique case (phase_q)
				PH_RELEASED: begin
					if (down) begin
						phase_d = PH_DEBOUNCE;
						hold_d  = '0;
					end
				end
				PH_DEBOUNCE: begin
					if (!down) begin
						phase_d = PH_RELEASED;
					end else if (hold_inc >= kdlp_pkg::HOLD_W'(thr.debounce_ticks)) begin
						phase_d = PH_PRESSED;
						hold_d  = '0;
					end else begin
						hold_d = hold_inc;
					end
				end
				PH_PRESSED: begin
					if (!down) begin
						phase_d   = PH_RELEASED;
						set_short = 1'b1;
					end else begin
						hold_d = hold_inc;
						if (hold_inc >= kdlp_pkg::HOLD_W'(thr.long_ticks)) begin
							phase_d = PH_LONG;
						end
					end
				end
				PH_LONG: begin
					if (!down) begin
						phase_d  = PH_RELEASED;
						set_long = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RELEASED;
			hold_q  <= '0;
			short_q <= 1'b0;
			long_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hold_q  <= hold_d;
			// Ticks and fetches never share a cycle, so set and clear cannot collide.
			short_q <= set_short | (short_q & ~clr.clr_short);
			long_q  <= set_long | (long_q & ~clr.clr_long);
		end
	end

	assign pend.short_pend = short_q;
	assign pend.long_pend  = long_q;

endmodule

`default_nettype wire

@@ rtl/core/kdlp_event_arb.sv @@
// Fixed-priority event picker: long presses before short ones, lowest key first.
// Depends on kdlp_pkg for the flag structs and the action code width.
`default_nettype none

module kdlp_event_arb #(
	parameter int KEY_COUNT = kdlp_pkg::KEY_COUNT_DEF
) (
	input  logic                                  fetch,
	input  kdlp_pkg::kdlp_pend_t [KEY_COUNT-1:0]  pend,
	output logic [kdlp_pkg::ACTION_W-1:0]         code,
	output kdlp_pkg::kdlp_clr_t [KEY_COUNT-1:0]   clr
);

	logic found;

	always_comb begin
		code  = kdlp_pkg::ACT_NONE;
		clr   = '0;
		found = 1'b0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (!found && pend[k].long_pend) begin
				found           = 1'b1;
				code            = kdlp_pkg::ACTION_W'(KEY_COUNT + 1 + k);
				clr[k].clr_long = fetch;
			end
		end
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (!found && pend[k].short_pend) begin
				found            = 1'b1;
				code             = kdlp_pkg::ACTION_W'(1 + k);
				clr[k].clr_short = fetch;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/key_debounce_long_press_detector.sv @@
// Channel    | Dir | Payload                   | Transfer when
// item       | in  | operation, keys_pressed   | item.valid && item.ready
// result     | out | action_code               | result.valid && result.ready
// cfg        | in  | index, data               | cfg.valid && cfg.ready (always ready)
//
// One item per cycle unless a fetch is stalled: each item is held in the input register,
// then all key lanes update (tick) or the event picker loads the result register (fetch).
// A fetch waits in the input register only while the result register holds an untaken result.
// Reset returns every key to released, clears all pending events and loads the default
// thresholds (debounce 1, long 100). No clearing pass is needed.
// Top level of the key debounce and press detector; depends on kdlp_pkg, kdlp_if,
// kdlp_key_fsm, kdlp_event_arb and the assertion macro header.
`default_nettype none
`include "key_debounce_long_press_detector_assert.svh"

module key_debounce_long_press_detector #(
	parameter int KEY_COUNT = kdlp_pkg::KEY_COUNT_DEF
) (
	input logic           clk,
	input logic           arst_n,
	kdlp_item_if.sink     item,
	kdlp_result_if.source result,
	kdlp_cfg_if.sink      cfg
);

	logic                          valid_s1;
	logic                          op_s1;
	logic [kdlp_pkg::KEYS_W-1:0]   keys_s1;
	logic                          out_valid_q;
	logic [kdlp_pkg::ACTION_W-1:0] action_q;
	kdlp_pkg::kdlp_thr_t           thr_q;

	logic tick_go;
	logic fetch_go;
	logic s1_free;

	kdlp_pkg::kdlp_pend_t [KEY_COUNT-1:0] pend;
	kdlp_pkg::kdlp_clr_t [KEY_COUNT-1:0]  clr;
	logic [kdlp_pkg::ACTION_W-1:0]        code;

	assign tick_go  = valid_s1 && (op_s1 == kdlp_pkg::OP_TICK);
	assign fetch_go = valid_s1 && (op_s1 == kdlp_pkg::OP_FETCH) && (!out_valid_q || result.ready);
	assign s1_free  = !valid_s1 || tick_go || fetch_go;

	assign item.ready = s1_free;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && item.valid) begin
			op_s1   <= item.operation;
			keys_s1 <= item.keys_pressed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fetch_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_go) begin
			action_q <= code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.debounce_ticks <= kdlp_pkg::DEB_RST;
			thr_q.long_ticks     <= kdlp_pkg::LONG_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				kdlp_pkg::CFG_DEBOUNCE: thr_q.debounce_ticks <= cfg.data[kdlp_pkg::DEB_W-1:0];
				kdlp_pkg::CFG_LONG:     thr_q.long_ticks     <= cfg.data[kdlp_pkg::LONG_W-1:0];
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.action_code = action_q;

	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
		logic down;

		// Keys beyond the sampled levels always read as released.
		if (k < kdlp_pkg::KEYS_W) begin : g_sampled
			assign down = keys_s1[k];
		end else begin : g_unsampled
			assign down = 1'b0;
		end

		kdlp_key_fsm u_key (
			.clk    (clk),
			.arst_n (arst_n),
			.tick   (tick_go),
			.down   (down),
			.thr    (thr_q),
			.clr    (clr[k]),
			.pend   (pend[k])
		);
	end

	kdlp_event_arb #(
		.KEY_COUNT (KEY_COUNT)
	) u_arb (
		.fetch (fetch_go),
		.pend  (pend),
		.code  (code),
		.clr   (clr)
	);

	`KDLP_ASSERT_NEXT(a_fetch_loads_result, clk, arst_n, fetch_go, out_valid_q)
	`KDLP_ASSERT_NEXT(a_tick_no_result, clk, arst_n, tick_go && !out_valid_q, !out_valid_q)
	`KDLP_ASSERT_NOW(a_one_clear, clk, arst_n, 1'b1, $onehot0(clr))
	`KDLP_ASSERT_NOW(a_clear_on_fetch, clk, arst_n, clr != '0, fetch_go)

endmodule

`default_nettype wire
